/* rtl/upd_pkg.sv */
// Shared types, character codes and hex helpers for the URL percent decoder.
`timescale 1ns / 1ps

package upd_pkg;

  // Character codes
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Result queue depth (power of two, room for at least two results)
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Escape tracking phase
  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_PCT    = 2'd1,
    PH_DIGIT  = 2'd2
  } phase_t;

  // One decoded result
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       end_of_string;
  } result_t;

  // Results caused by one input request
  typedef struct packed {
    logic [1:0] n_res;
    result_t    res0;
    result_t    res1;
  } step_t;

  // True for 0-9, A-F, a-f
  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Nibble value of a hex digit character
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h41 + 8'd10;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h61 + 8'd10;
    end
    hex_val = v[3:0];
  endfunction

endpackage

/* rtl/url_percent_decoder.sv */
// Top level of the streaming URL percent decoder.
`timescale 1ns / 1ps

// Decodes a form-urlencoded byte stream: "%hh" becomes one byte, a '%' without a
// valid hex pair is dropped (the bytes after it pass as ordinary bytes), and '+'
// becomes a space while plus_as_space is set (reset value 1). The block takes one
// byte per cycle while its input register is free; a byte passes that register
// and the decode logic into a four-entry result queue, which stores its results
// and offers them from its head. A byte that breaks an escape can cause two
// results, which then leave the queue one at a time; the input register is free to
// take a byte while it is empty or while the queue holds at most two results.
// A result with byte_valid low is an end-only marker carrying end_of_string.
module url_percent_decoder (
  input  logic       clk,
  input  logic       rst_n,
  // Input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // last_of_string
  // Result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] byte_valid, [1] last_of_run
  output logic       out_tlast,  // end_of_string
  // Configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data // plus_as_space
);
  import upd_pkg::*;

  logic             pas_r;
  logic             in_v_r, in_v_nxt;
  logic [7:0]       in_byte_r;
  logic             in_last_r;
  phase_t           phase_r, phase_dec;
  logic [7:0]       held_r, held_dec;
  step_t            step;
  logic             room;
  logic             dec_fire;
  logic             in_fire;
  logic [CNT_W-1:0] q_count;
  result_t          head;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pas_r <= 1'b1;
    end else if (cfg_wr_en) begin
      pas_r <= cfg_wr_data;
    end
  end

  // Input register handshake
  assign room      = (q_count <= CNT_W'(QUEUE_DEPTH - 2));
  assign dec_fire  = in_v_r && room;
  assign in_tready = !in_v_r || room;
  assign in_fire   = in_tvalid && in_tready;
  assign in_v_nxt  = in_tready ? in_tvalid : in_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Decode one byte
  upd_decode u_decode (
    .phase_i         (phase_r),
    .held_i          (held_r),
    .byte_i          (in_byte_r),
    .last_i          (in_last_r),
    .plus_as_space_i (pas_r),
    .phase_o         (phase_dec),
    .held_o          (held_dec),
    .step_o          (step)
  );

  // Escape state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      held_r  <= 8'h00;
    end else if (dec_fire) begin
      phase_r <= phase_dec;
      held_r  <= held_dec;
    end
  end

  // Queue results toward the output
  upd_res_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (step),
    .push_en_i (dec_fire),
    .pop_i     (out_tvalid && out_tready),
    .valid_o   (out_tvalid),
    .head_o    (head),
    .count_o   (q_count)
  );

  assign out_tdata = head.out_byte;
  assign out_tuser = {head.last_of_run, head.byte_valid};
  assign out_tlast = head.end_of_string;

  // Queue never overfills
  assert property (@(posedge clk) disable iff (!rst_n) q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  // End of string always yields a result and returns to the normal phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (dec_fire && in_last_r) |-> (step.n_res != 2'd0))
    else $error("end of string produced no result");

  assert property (@(posedge clk) disable iff (!rst_n)
    (dec_fire && in_last_r) |=> (phase_r == PH_NORMAL))
    else $error("escape phase not cleared at end of string");

endmodule

/* rtl/upd_decode.sv */
// Combinational per-byte decode step: escape tracking and result generation.
`timescale 1ns / 1ps

module upd_decode (
  input  upd_pkg::phase_t  phase_i,
  input  logic [7:0]       held_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  input  logic             plus_as_space_i,
  output upd_pkg::phase_t  phase_o,
  output logic [7:0]       held_o,
  output upd_pkg::step_t   step_o
);
  import upd_pkg::*;

  result_t    res [2];
  logic [1:0] n;
  phase_t     ph;
  logic [7:0] hd;
  logic       is_pct;
  logic [7:0] plain_val;
  logic       byte_hex;

  assign is_pct    = (byte_i == CH_PERCENT);
  assign byte_hex  = is_hex(byte_i);
  assign plain_val = (byte_i == CH_PLUS && plus_as_space_i) ? CH_SPACE : byte_i;

  always_comb begin
    res[0] = '0;
    res[1] = '0;
    n      = 2'd0;
    ph     = phase_i;
    hd     = held_i;

    // Walk the escape phase
    case (phase_i)
      PH_PCT: begin
        if (byte_hex) begin
          hd = byte_i;
          ph = PH_DIGIT;
        end else if (is_pct) begin
          ph = PH_PCT;
        end else begin
          ph = PH_NORMAL;
          res[n[0]].out_byte   = plain_val;
          res[n[0]].byte_valid = 1'b1;
          n = n + 2'd1;
        end
      end
      PH_DIGIT: begin
        if (byte_hex) begin
          res[n[0]].out_byte   = {hex_val(held_i), hex_val(byte_i)};
          res[n[0]].byte_valid = 1'b1;
          n  = n + 2'd1;
          ph = PH_NORMAL;
        end else begin
          // Broken escape: release the held digit, then handle byte normally
          res[n[0]].out_byte   = held_i;
          res[n[0]].byte_valid = 1'b1;
          n = n + 2'd1;
          if (is_pct) begin
            ph = PH_PCT;
          end else begin
            ph = PH_NORMAL;
            res[n[0]].out_byte   = plain_val;
            res[n[0]].byte_valid = 1'b1;
            n = n + 2'd1;
          end
        end
      end
      default: begin
        if (is_pct) begin
          ph = PH_PCT;
        end else begin
          ph = PH_NORMAL;
          res[n[0]].out_byte   = plain_val;
          res[n[0]].byte_valid = 1'b1;
          n = n + 2'd1;
        end
      end
    endcase

    // Close the string: flush a held digit, mark the end
    if (last_i) begin
      if (ph == PH_DIGIT) begin
        res[n[0]].out_byte   = hd;
        res[n[0]].byte_valid = 1'b1;
        n = n + 2'd1;
      end
      ph = PH_NORMAL;
      if (n == 2'd0) begin
        n = 2'd1;
      end
      res[n[0] ^ 1'b1].end_of_string = 1'b1;
    end

    // Mark the final result of this request
    if (n != 2'd0) begin
      res[n[0] ^ 1'b1].last_of_run = 1'b1;
    end
  end

  assign phase_o      = ph;
  assign held_o       = hd;
  assign step_o.n_res = n;
  assign step_o.res0  = res[0];
  assign step_o.res1  = res[1];

endmodule

/* rtl/upd_res_queue.sv */
// Small result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps

module upd_res_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  upd_pkg::step_t          push_i,
  input  logic                    push_en_i,
  input  logic                    pop_i,
  output logic                    valid_o,
  output upd_pkg::result_t        head_o,
  output logic [upd_pkg::CNT_W-1:0] count_o
);
  import upd_pkg::*;

  result_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [1:0]           n_push;
  logic [PTR_W-1:0]     wr_ptr_p1;

  assign n_push    = push_en_i ? push_i.n_res : 2'd0;
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(n_push);
    rd_ptr_nxt = pop_i ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + CNT_W'(n_push) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store new results
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr_r] <= push_i.res0;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr_p1] <= push_i.res1;
    end
  end

  assign valid_o = (count_r != '0);
  assign head_o  = mem[rd_ptr_r];
  assign count_o = count_r;

endmodule
